// File: rtl/core/lcsf_pkg.sv
// ----------------------------------------------------------------------------
// lcsf_pkg
// Shared types and constants of the load cell sample filter: filter depth,
// derived widths, register indexes, fault codes and sequencer states.
// ----------------------------------------------------------------------------
package lcsf_pkg;

   localparam int FILTER_DEPTH = 16;

   localparam int WEIGHT_W = 16;
   localparam int RAW_W    = 16;
   localparam int GAIN_W   = 24;
   localparam int WINDOW_W = 5;
   localparam int HYST_W   = 16;
   localparam int ERRLIM_W = 8;
   localparam int STKLIM_W = 16;
   localparam int PROD_W   = WEIGHT_W + GAIN_W;

   // Ring pointer, entry count and accumulator widths follow the depth.
   localparam int PTR_W  = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
   localparam int CNT_W  = $clog2(FILTER_DEPTH + 1);
   localparam int SUM_W  = WEIGHT_W + CNT_W;
   localparam int WIDE_W = (CNT_W > WINDOW_W) ? CNT_W : WINDOW_W;
   localparam int STEP_W = $clog2(SUM_W + 1);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_TARE       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HYSTERESIS = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ERROR_LIM  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_STUCK_LIM  = 3'd5;

   localparam logic [RAW_W-1:0]    READ_ERROR_CODE = 16'hFFFF;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX      = 16'hFFFF;

   typedef enum logic [1:0] {
      FAULT_NONE  = 2'd0,
      FAULT_ERROR = 2'd1,
      FAULT_STUCK = 2'd2
   } fault_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCALE,
      ST_WRITE,
      ST_READ,
      ST_DIVIDE,
      ST_UPDATE,
      ST_DONE
   } state_type;

endpackage

// File: rtl/core/lcsf_ring.sv
// ----------------------------------------------------------------------------
// lcsf_ring
// Weight ring memory: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module lcsf_ring
   import lcsf_pkg::*;
(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [PTR_W-1:0]    wr_addr,
   input  logic [WEIGHT_W-1:0] wr_data,
   input  logic                rd_en,
   input  logic [PTR_W-1:0]    rd_addr,
   output logic [WEIGHT_W-1:0] rd_data
);

   logic [WEIGHT_W-1:0] mem [FILTER_DEPTH];
   logic [WEIGHT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/lcsf_divider.sv
// ----------------------------------------------------------------------------
// lcsf_divider
// Restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcsf_divider
   import lcsf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic             done,
   output logic [SUM_W-1:0] quotient
);

   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W:0]    trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[SUM_W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = STEP_W'(SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so it fits CNT_W bits.
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = CNT_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      step_ff <= step_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/core/load_cell_sample_filter.sv
// ----------------------------------------------------------------------------
// load_cell_sample_filter
// Watchdog, tare and gain scaling, moving average and hysteresis for load
// cell converter samples.
// ----------------------------------------------------------------------------
// One word is taken at a time. A clear, a failed sensor, an error code, a stuck
// hit or a sample out of position passes from the check state to the done
// state, which registers its result on the output once the output is free, and
// the next word can be taken when the sequencer is back in idle. A sample in
// position also passes the scale, write, read, divide and update states: the
// ring is read one entry a cycle into a single accumulator and the mean comes
// from a one-bit-per-cycle divider. The input stalls while an item is at work;
// a finished result may wait on the output while the next word is taken.
// Configuration writes are always ready.
// ----------------------------------------------------------------------------
module load_cell_sample_filter
   import lcsf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_action,
   input  logic [RAW_W-1:0]       req_raw_sample,
   input  logic                   req_in_position,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [WEIGHT_W-1:0]    rsp_shown_weight,
   output logic [WEIGHT_W-1:0]    rsp_instant_weight,
   output logic                   rsp_sensor_ok,
   output logic [1:0]             rsp_fault_cause,
   output logic                   rsp_shown_changed,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Configuration registers.
   logic signed [RAW_W-1:0] tare_ff;
   logic [GAIN_W-1:0]       gain_ff;
   logic [WINDOW_W-1:0]     window_ff;
   logic [HYST_W-1:0]       hyst_ff;
   logic [ERRLIM_W-1:0]     err_lim_ff;
   logic [STKLIM_W-1:0]     stk_lim_ff;

   // Sequencer and filter state.
   state_type            state_ff, state_in;
   logic                 action_ff, action_in;
   logic [RAW_W-1:0]     raw_ff, raw_in;
   logic                 pos_ff, pos_in;
   logic [PTR_W-1:0]     wpos_ff, wpos_in;
   logic [CNT_W-1:0]     fill_ff, fill_in;
   logic [WEIGHT_W-1:0]  last_ff, last_in;
   logic [WEIGHT_W-1:0]  shown_ff, shown_in;
   logic [WEIGHT_W-1:0]  inst_ff, inst_in;
   logic                 alive_ff, alive_in;
   logic [ERRLIM_W-1:0]  err_run_ff, err_run_in;
   logic [STKLIM_W-1:0]  same_run_ff, same_run_in;
   logic [RAW_W-1:0]     prev_ff, prev_in;
   fault_type            cause_ff, cause_in;
   logic                 changed_ff, changed_in;
   logic                 dpos_ff, dpos_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [CNT_W-1:0]     issued_ff, issued_in;
   logic [PTR_W-1:0]     rptr_ff, rptr_in;
   logic                 pending_ff, pending_in;
   logic [SUM_W-1:0]     acc_ff, acc_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WEIGHT_W-1:0]  rsp_shown_ff, rsp_shown_in;
   logic [WEIGHT_W-1:0]  rsp_inst_ff, rsp_inst_in;
   logic                 rsp_ok_ff, rsp_ok_in;
   fault_type            rsp_cause_ff, rsp_cause_in;
   logic                 rsp_changed_ff, rsp_changed_in;

   // Datapath helpers.
   logic signed [RAW_W:0] diff_counts;
   logic [WEIGHT_W-1:0]   weight;
   logic [WIDE_W-1:0]     win_wide;
   logic [WIDE_W-1:0]     fill_wide;
   logic [CNT_W-1:0]      fill_next;
   logic [WEIGHT_W-1:0]   mean;
   logic [WEIGHT_W-1:0]   delta;
   logic                  ring_we;
   logic                  ring_re;
   logic [WEIGHT_W-1:0]   ring_rdata;
   logic                  div_start;
   logic                  div_done;
   logic [SUM_W-1:0]      div_quotient;
   logic                  accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tare_ff    <= '0;
         gain_ff    <= GAIN_W'(65536);
         window_ff  <= WINDOW_W'(8);
         hyst_ff    <= '0;
         err_lim_ff <= ERRLIM_W'(5);
         stk_lim_ff <= STKLIM_W'(50);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TARE:       tare_ff    <= csr_wdata[RAW_W-1:0];
            CSR_GAIN:       gain_ff    <= csr_wdata[GAIN_W-1:0];
            CSR_WINDOW:     window_ff  <= csr_wdata[WINDOW_W-1:0];
            CSR_HYSTERESIS: hyst_ff    <= csr_wdata[HYST_W-1:0];
            CSR_ERROR_LIM:  err_lim_ff <= csr_wdata[ERRLIM_W-1:0];
            CSR_STUCK_LIM:  stk_lim_ff <= csr_wdata[STKLIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   lcsf_ring u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (wpos_ff),
      .wr_data (weight),
      .rd_en   (ring_re),
      .rd_addr (rptr_ff),
      .rd_data (ring_rdata)
   );

   lcsf_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (n_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign diff_counts = (RAW_W+1)'($signed(raw_ff)) - (RAW_W+1)'(tare_ff);

   // Truncated product, zero for a non-positive difference, saturated at the top.
   always_comb begin
      if (!dpos_ff) begin
         weight = '0;
      end else if (|prod_ff[PROD_W-1:WEIGHT_W+16]) begin
         weight = WEIGHT_MAX;
      end else begin
         weight = prod_ff[WEIGHT_W+15:16];
      end
   end

   assign fill_next = (fill_ff == CNT_W'(FILTER_DEPTH)) ? fill_ff : fill_ff + 1'b1;
   assign fill_wide = WIDE_W'(fill_next);
   assign win_wide  = (window_ff == '0) ? WIDE_W'(1) : WIDE_W'(window_ff);
   assign mean      = div_quotient[WEIGHT_W-1:0];
   assign delta     = (mean >= last_ff) ? mean - last_ff : last_ff - mean;

   always_comb begin
      state_in    = state_ff;
      action_in   = action_ff;
      raw_in      = raw_ff;
      pos_in      = pos_ff;
      wpos_in     = wpos_ff;
      fill_in     = fill_ff;
      last_in     = last_ff;
      shown_in    = shown_ff;
      inst_in     = inst_ff;
      alive_in    = alive_ff;
      err_run_in  = err_run_ff;
      same_run_in = same_run_ff;
      prev_in     = prev_ff;
      cause_in    = cause_ff;
      changed_in  = changed_ff;
      dpos_in     = dpos_ff;
      prod_in     = prod_ff;
      n_in        = n_ff;
      issued_in   = issued_ff;
      rptr_in     = rptr_ff;
      pending_in  = 1'b0;
      acc_in      = acc_ff;
      ring_we     = 1'b0;
      ring_re     = 1'b0;
      div_start   = 1'b0;

      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_shown_in   = rsp_shown_ff;
      rsp_inst_in    = rsp_inst_ff;
      rsp_ok_in      = rsp_ok_ff;
      rsp_cause_in   = rsp_cause_ff;
      rsp_changed_in = rsp_changed_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               action_in  = req_action;
               raw_in     = req_raw_sample;
               pos_in     = req_in_position;
               cause_in   = FAULT_NONE;
               changed_in = 1'b0;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = ST_DONE;
            if (action_ff) begin
               wpos_in  = '0;
               fill_in  = '0;
               last_in  = '0;
               shown_in = '0;
            end else if (alive_ff) begin
               if (raw_ff == READ_ERROR_CODE) begin
                  err_run_in = (err_run_ff == '1) ? err_run_ff : err_run_ff + 1'b1;
                  if (err_run_in >= err_lim_ff) begin
                     alive_in   = 1'b0;
                     err_run_in = '0;
                     cause_in   = FAULT_ERROR;
                  end
               end else begin
                  err_run_in = '0;
                  if (raw_ff == prev_ff) begin
                     same_run_in = (same_run_ff == '1) ? same_run_ff : same_run_ff + 1'b1;
                     if (same_run_in >= stk_lim_ff) begin
                        alive_in    = 1'b0;
                        same_run_in = '0;
                        cause_in    = FAULT_STUCK;
                     end else if (pos_ff) begin
                        state_in = ST_SCALE;
                     end
                  end else begin
                     same_run_in = '0;
                     prev_in     = raw_ff;
                     if (pos_ff) begin
                        state_in = ST_SCALE;
                     end
                  end
               end
            end
         end
         ST_SCALE: begin
            dpos_in  = (diff_counts > 0);
            prod_in  = PROD_W'(diff_counts[WEIGHT_W-1:0]) * PROD_W'(gain_ff);
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            ring_we   = 1'b1;
            inst_in   = weight;
            wpos_in   = (wpos_ff == PTR_W'(FILTER_DEPTH - 1)) ? '0 : wpos_ff + 1'b1;
            fill_in   = fill_next;
            n_in      = (win_wide < fill_wide) ? CNT_W'(win_wide) : fill_next;
            rptr_in   = wpos_ff;
            issued_in = '0;
            acc_in    = '0;
            state_in  = ST_READ;
         end
         ST_READ: begin
            // Reads walk back from the newest entry; the registered data lands in the next cycle.
            if (pending_ff) begin
               acc_in = acc_ff + SUM_W'(ring_rdata);
            end
            if (issued_ff != n_ff) begin
               ring_re    = 1'b1;
               pending_in = 1'b1;
               issued_in  = issued_ff + 1'b1;
               rptr_in    = (rptr_ff == '0) ? PTR_W'(FILTER_DEPTH - 1) : rptr_ff - 1'b1;
            end else if (!pending_ff) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (delta >= hyst_ff) begin
               shown_in   = mean;
               last_in    = mean;
               changed_in = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_shown_in   = shown_ff;
               rsp_inst_in    = inst_ff;
               rsp_ok_in      = alive_ff;
               rsp_cause_in   = cause_ff;
               rsp_changed_in = changed_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wpos_ff      <= '0;
         fill_ff      <= '0;
         last_ff      <= '0;
         shown_ff     <= '0;
         inst_ff      <= '0;
         alive_ff     <= 1'b1;
         err_run_ff   <= '0;
         same_run_ff  <= '0;
         prev_ff      <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wpos_ff      <= wpos_in;
         fill_ff      <= fill_in;
         last_ff      <= last_in;
         shown_ff     <= shown_in;
         inst_ff      <= inst_in;
         alive_ff     <= alive_in;
         err_run_ff   <= err_run_in;
         same_run_ff  <= same_run_in;
         prev_ff      <= prev_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff      <= action_in;
      raw_ff         <= raw_in;
      pos_ff         <= pos_in;
      cause_ff       <= cause_in;
      changed_ff     <= changed_in;
      dpos_ff        <= dpos_in;
      prod_ff        <= prod_in;
      n_ff           <= n_in;
      issued_ff      <= issued_in;
      rptr_ff        <= rptr_in;
      acc_ff         <= acc_in;
      rsp_shown_ff   <= rsp_shown_in;
      rsp_inst_ff    <= rsp_inst_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_cause_ff   <= rsp_cause_in;
      rsp_changed_ff <= rsp_changed_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_shown_weight   = rsp_shown_ff;
   assign rsp_instant_weight = rsp_inst_ff;
   assign rsp_sensor_ok      = rsp_ok_ff;
   assign rsp_fault_cause    = rsp_cause_ff;
   assign rsp_shown_changed  = rsp_changed_ff;

endmodule

// File: sim/load_cell_sample_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_cell_sample_filter_tb
// Self-checking bench for the load cell sample filter. A tracker class keeps
// its own copy of the watchdog, scaling, ring and hysteresis state, predicts
// one reading per accepted sample word and checks every result word against
// the oldest prediction. A short directed run is followed by random phases
// with fresh register settings, random idle gaps and output stalls.
// ----------------------------------------------------------------------------
import lcsf_pkg::*;

typedef struct packed {
   logic [WEIGHT_W-1:0] shown;
   logic [WEIGHT_W-1:0] instant;
   logic                ok;
   fault_type           cause;
   logic                changed;
} filter_reading_type;

class weight_tracker;
   logic signed [RAW_W-1:0] tare;
   logic [GAIN_W-1:0]       gain;
   logic [WINDOW_W-1:0]     window;
   logic [HYST_W-1:0]       hyst;
   logic [ERRLIM_W-1:0]     err_lim;
   logic [STKLIM_W-1:0]     stuck_lim;

   logic [WEIGHT_W-1:0] ring [FILTER_DEPTH];
   logic [PTR_W-1:0]    wr_pos;
   logic [CNT_W-1:0]    fill;
   logic [WEIGHT_W-1:0] last_shown;
   logic [WEIGHT_W-1:0] shown;
   logic [WEIGHT_W-1:0] instant;
   logic                alive;
   logic [ERRLIM_W-1:0] err_run;
   logic [STKLIM_W-1:0] same_run;
   logic [RAW_W-1:0]    prev_raw;

   filter_reading_type expected_readings [$];
   int mismatches;

   function new();
      tare       = '0;
      gain       = 24'd65536;
      window     = 5'd8;
      hyst       = '0;
      err_lim    = 8'd5;
      stuck_lim  = 16'd50;
      instant    = '0;
      alive      = 1'b1;
      err_run    = '0;
      same_run   = '0;
      prev_raw   = '0;
      mismatches = 0;
      clear_ring();
   endfunction

   function void clear_ring();
      for (int i = 0; i < FILTER_DEPTH; i++)
         ring[i] = '0;
      wr_pos     = '0;
      fill       = '0;
      last_shown = '0;
      shown      = '0;
   endfunction

   function void write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_TARE:       tare      = data[RAW_W-1:0];
         CSR_GAIN:       gain      = data[GAIN_W-1:0];
         CSR_WINDOW:     window    = data[WINDOW_W-1:0];
         CSR_HYSTERESIS: hyst      = data[HYST_W-1:0];
         CSR_ERROR_LIM:  err_lim   = data[ERRLIM_W-1:0];
         CSR_STUCK_LIM:  stuck_lim = data[STKLIM_W-1:0];
         default: ;
      endcase
   endfunction

   // Offset-corrected count times the Q8.16 gain, clamped to 0..65535.
   function logic [WEIGHT_W-1:0] scale(logic [RAW_W-1:0] raw);
      longint d;
      longint w;
      d = longint'($signed(raw)) - longint'(tare);
      if (d <= 0)
         return '0;
      w = (d * longint'(gain)) >>> 16;
      if (w > 65535)
         return WEIGHT_MAX;
      return w[WEIGHT_W-1:0];
   endfunction

   // True when this word would mark the sensor failed.
   function bit would_trip(logic act, logic [RAW_W-1:0] raw);
      if (act || !alive)
         return 1'b0;
      if (raw == READ_ERROR_CODE)
         return ((err_run == 8'hFF) ? err_run : err_run + 8'd1) >= err_lim;
      if (raw == prev_raw)
         return ((same_run == 16'hFFFF) ? same_run : same_run + 16'd1) >= stuck_lim;
      return 1'b0;
   endfunction

   function void note_word(logic act, logic [RAW_W-1:0] raw, logic pos);
      filter_reading_type r;
      fault_type          cause;
      logic               changed;
      logic               stuck;
      int                 win;
      int                 n;
      int                 sum;
      int                 mean;
      int                 diff;
      cause   = FAULT_NONE;
      changed = 1'b0;
      stuck   = 1'b0;
      if (act) begin
         clear_ring();
      end else if (alive) begin
         if (raw == READ_ERROR_CODE) begin
            if (err_run != 8'hFF)
               err_run = err_run + 8'd1;
            if (err_run >= err_lim) begin
               alive   = 1'b0;
               err_run = '0;
               cause   = FAULT_ERROR;
            end
         end else begin
            err_run = '0;
            if (raw == prev_raw) begin
               if (same_run != 16'hFFFF)
                  same_run = same_run + 16'd1;
               if (same_run >= stuck_lim) begin
                  alive    = 1'b0;
                  same_run = '0;
                  cause    = FAULT_STUCK;
                  stuck    = 1'b1;
               end
            end else begin
               same_run = '0;
               prev_raw = raw;
            end
            if (!stuck && pos) begin
               instant      = scale(raw);
               ring[wr_pos] = instant;
               wr_pos       = PTR_W'((int'(wr_pos) + 1) % FILTER_DEPTH);
               if (fill < FILTER_DEPTH)
                  fill = fill + 1'b1;
               win = (window == 0) ? 1 : int'(window);
               n   = (win < int'(fill)) ? win : int'(fill);
               sum = 0;
               for (int i = 0; i < n; i++)
                  sum += ring[(int'(wr_pos) + FILTER_DEPTH - 1 - i) % FILTER_DEPTH];
               mean = sum / n;
               diff = (mean >= int'(last_shown)) ? mean - int'(last_shown)
                                                 : int'(last_shown) - mean;
               if (diff >= int'(hyst)) begin
                  shown      = WEIGHT_W'(mean);
                  last_shown = WEIGHT_W'(mean);
                  changed    = 1'b1;
               end
            end
         end
      end
      r.shown   = shown;
      r.instant = instant;
      r.ok      = alive;
      r.cause   = cause;
      r.changed = changed;
      expected_readings.push_back(r);
   endfunction

   function void report_field(string field, int unsigned want, int unsigned got);
      mismatches++;
      $error("%s: expected %0d, actual %0d", field, want, got);
   endfunction

   function void check_word(logic [WEIGHT_W-1:0] shown_w, logic [WEIGHT_W-1:0] instant_w,
                            logic ok, logic [1:0] cause, logic changed);
      filter_reading_type e;
      if (expected_readings.size() == 0) begin
         report_field("result word with no prediction, shown_weight", 0, shown_w);
         return;
      end
      e = expected_readings.pop_front();
      if (shown_w !== e.shown)
         report_field("shown_weight", e.shown, shown_w);
      if (instant_w !== e.instant)
         report_field("instant_weight", e.instant, instant_w);
      if (ok !== e.ok)
         report_field("sensor_ok", e.ok, ok);
      if (cause !== e.cause)
         report_field("fault_cause", e.cause, cause);
      if (changed !== e.changed)
         report_field("shown_changed", e.changed, changed);
   endfunction

   function int pending();
      return expected_readings.size();
   endfunction
endclass

module load_cell_sample_filter_tb;

   localparam int HALF_PERIOD   = 10;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int DRAIN_CYCLES  = 100;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_WORDS   = 135;

   logic                   clock           = 1'b0;
   logic                   reset           = 1'b1;
   logic                   req_valid       = 1'b0;
   logic                   req_action      = 1'b0;
   logic [RAW_W-1:0]       req_raw_sample  = '0;
   logic                   req_in_position = 1'b0;
   logic                   rsp_stall       = 1'b0;
   logic                   csr_valid       = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index       = CSR_TARE;
   logic [CSR_DATA_W-1:0]  csr_wdata       = '0;

   logic                   req_stall;
   logic                   rsp_valid;
   logic [WEIGHT_W-1:0]    rsp_shown_weight;
   logic [WEIGHT_W-1:0]    rsp_instant_weight;
   logic                   rsp_sensor_ok;
   logic [1:0]             rsp_fault_cause;
   logic                   rsp_shown_changed;
   logic                   csr_ready;

   weight_tracker tracker;
   bit            gaps_on    = 1'b1;
   bit            stalls_on  = 1'b1;
   int            next_gap   = 0;
   int            stall_hold = 0;
   int            cycle_count = 0;

   load_cell_sample_filter u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_raw_sample     (req_raw_sample),
      .req_in_position    (req_in_position),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_shown_weight   (rsp_shown_weight),
      .rsp_instant_weight (rsp_instant_weight),
      .rsp_sensor_ok      (rsp_sensor_ok),
      .rsp_fault_cause    (rsp_fault_cause),
      .rsp_shown_changed  (rsp_shown_changed),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Mostly short idle stretches, now and then a long one.
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 88)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (stall_hold > 0) begin
         stall_hold--;
      end else if (stalls_on && $urandom_range(0, 99) < 35) begin
         rsp_stall  <= 1'b1;
         stall_hold = idle_cycles();
      end else begin
         rsp_stall  <= 1'b0;
         stall_hold = $urandom_range(0, 4);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_word(rsp_shown_weight, rsp_instant_weight, rsp_sensor_ok,
                            rsp_fault_cause, rsp_shown_changed);
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** load_cell_sample_filter: FAILED **");
      $finish;
   end

   // The gap before the next word is drawn at acceptance, so that valid
   // either stays high for a back-to-back word or drops in the same step.
   task automatic send_word(input logic act, input logic [RAW_W-1:0] raw, input logic pos);
      repeat (next_gap) @(posedge clock);
      req_valid       <= 1'b1;
      req_action      <= act;
      req_raw_sample  <= raw;
      req_in_position <= pos;
      do @(posedge clock); while (req_stall);
      tracker.note_word(act, raw, pos);
      next_gap = gaps_on ? idle_cycles() : 0;
      if (next_gap > 0)
         req_valid <= 1'b0;
   endtask

   task automatic hold_requests();
      if (next_gap == 0)
         req_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      hold_requests();
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      tracker.write_register(idx, data);
   endtask

   task automatic set_register(input logic [CSR_INDEX_W-1:0] idx,
                               input logic [CSR_DATA_W-1:0] data);
      wait_idle();
      write_register(idx, data);
      csr_valid <= 1'b0;
   endtask

   task automatic load_settings(input logic signed [RAW_W-1:0] t, input logic [GAIN_W-1:0] g,
                                input logic [WINDOW_W-1:0] w, input logic [HYST_W-1:0] h,
                                input logic [ERRLIM_W-1:0] el, input logic [STKLIM_W-1:0] sl);
      wait_idle();
      write_register(CSR_TARE, {{(CSR_DATA_W - RAW_W){t[RAW_W-1]}}, t});
      write_register(CSR_GAIN, g);
      write_register(CSR_WINDOW, CSR_DATA_W'(w));
      write_register(CSR_HYSTERESIS, CSR_DATA_W'(h));
      write_register(CSR_ERROR_LIM, CSR_DATA_W'(el));
      write_register(CSR_STUCK_LIM, CSR_DATA_W'(sl));
      csr_valid <= 1'b0;
   endtask

   task automatic random_settings();
      logic signed [RAW_W-1:0] t;
      logic [GAIN_W-1:0]       g;
      logic [WINDOW_W-1:0]     w;
      logic [HYST_W-1:0]       h;
      logic [ERRLIM_W-1:0]     el;
      logic [STKLIM_W-1:0]     sl;
      int                      r;
      r = $urandom_range(0, 9);
      if (r == 0)      t = 16'sh8000;
      else if (r == 1) t = 16'sh7FFF;
      else if (r == 2) t = '0;
      else if (r < 7)  t = RAW_W'($urandom_range(0, 4000)) - 16'd2000;
      else             t = RAW_W'($urandom);
      r = $urandom_range(0, 9);
      if (r == 0)      g = '0;
      else if (r == 1) g = 24'hFFFFFF;
      else if (r == 2) g = 24'd65536;
      else if (r < 7)  g = GAIN_W'($urandom_range(16000, 200000));
      else             g = GAIN_W'($urandom);
      r = $urandom_range(0, 19);
      if (r == 0)      w = '0;
      else if (r == 1) w = 5'd1;
      else if (r < 4)  w = 5'd16;
      else if (r < 6)  w = WINDOW_W'($urandom_range(17, 31));
      else             w = WINDOW_W'($urandom_range(2, 15));
      r = $urandom_range(0, 9);
      if (r < 4)       h = '0;
      else if (r == 4) h = 16'hFFFF;
      else if (r < 8)  h = HYST_W'($urandom_range(1, 200));
      else             h = HYST_W'($urandom);
      r = $urandom_range(0, 9);
      if (r < 3)       el = ERRLIM_W'($urandom_range(1, 4));
      else if (r == 3) el = 8'd255;
      else             el = ERRLIM_W'($urandom_range(5, 12));
      r = $urandom_range(0, 9);
      if (r < 5)       sl = STKLIM_W'($urandom_range(2, 8));
      else if (r == 5) sl = 16'hFFFF;
      else if (r == 6) sl = 16'd1;
      else             sl = STKLIM_W'($urandom_range(9, 300));
      load_settings(t, g, w, h, el, sl);
   endtask

   function automatic logic [RAW_W-1:0] pick_raw();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)
         return READ_ERROR_CODE;
      if (r < 26)
         return tracker.prev_raw;
      if (r < 36) begin
         case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'h0001;
            default: return 16'hFFFE;
         endcase
      end
      if (r < 70)
         return RAW_W'(tracker.tare) + RAW_W'($urandom_range(0, 700)) - 16'd150;
      return RAW_W'($urandom);
   endfunction

   // A reading that neither is the error code nor repeats the last one.
   function automatic logic [RAW_W-1:0] fresh_raw();
      logic [RAW_W-1:0] v;
      v = tracker.prev_raw + 16'd2;
      if (v == READ_ERROR_CODE)
         v = 16'h1234;
      return v;
   endfunction

   // The sensor can only fail once per run, so random words that would
   // trip the watchdog are swapped for a fresh reading.
   task automatic send_random_word(input bit keep_alive);
      logic             act;
      logic [RAW_W-1:0] raw;
      logic             pos;
      act = ($urandom_range(0, 99) < 4);
      raw = pick_raw();
      pos = ($urandom_range(0, 99) < 85);
      if (keep_alive && tracker.would_trip(act, raw))
         raw = fresh_raw();
      send_word(act, raw, pos);
   endtask

   initial begin : stimulus
      bit               error_kind;
      int               limit;
      logic [RAW_W-1:0] v;
      tracker = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: unit gain, no tare, window of eight.
      send_word(1'b0, 16'd100, 1'b0);
      send_word(1'b0, 16'h0000, 1'b1);
      send_word(1'b0, 16'h7FFF, 1'b1);
      send_word(1'b0, 16'h8000, 1'b1);
      send_word(1'b0, 16'h0001, 1'b1);
      send_word(1'b0, READ_ERROR_CODE, 1'b1);
      send_word(1'b0, READ_ERROR_CODE, 1'b0);
      send_word(1'b0, 16'h0001, 1'b1);
      send_word(1'b1, 16'h5555, 1'b1);
      send_word(1'b0, 16'h2AAA, 1'b1);
      send_word(1'b0, 16'h2AAB, 1'b1);

      // Largest gain against the most negative tare saturates; window of zero.
      load_settings(16'sh8000, 24'hFFFFFF, 5'd0, 16'hFFFF, 8'd255, 16'hFFFF);
      send_word(1'b0, 16'h7FFF, 1'b1);
      send_word(1'b0, 16'h8000, 1'b1);
      send_word(1'b0, 16'h8001, 1'b1);

      // Zero gain, window wider than the ring.
      load_settings(16'sh7FFF, 24'd0, 5'd31, 16'd0, 8'd2, 16'd2);
      send_word(1'b0, 16'h7FFF, 1'b1);
      send_word(1'b0, 16'h8000, 1'b1);
      send_word(1'b1, 16'h0000, 1'b0);
      send_word(1'b0, 16'h7FFE, 1'b1);

      // Full window with a small hysteresis step.
      load_settings(16'sd0, 24'd65536, 5'd16, 16'd10, 8'd5, 16'd50);
      send_word(1'b0, 16'd100, 1'b1);
      send_word(1'b0, 16'd105, 1'b1);
      send_word(1'b0, 16'd200, 1'b1);
      send_word(1'b0, 16'd200, 1'b1);
      send_word(1'b0, 16'd50, 1'b1);
      send_word(1'b0, READ_ERROR_CODE, 1'b1);
      send_word(1'b0, 16'd7, 1'b0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         random_settings();
         gaps_on   = (p == 2) ? 1'b0 : ($urandom_range(0, 9) < 8);
         stalls_on = (p == 2) ? 1'b0 : ($urandom_range(0, 9) < 8);
         repeat (PHASE_WORDS) send_random_word(1'b1);
      end

      // Finally let the watchdog fire, by error codes or by a stuck reading.
      gaps_on    = 1'b1;
      stalls_on  = 1'b1;
      error_kind = $urandom_range(0, 1);
      limit      = $urandom_range(0, 3);
      if (error_kind) begin
         set_register(CSR_ERROR_LIM, CSR_DATA_W'(limit));
         repeat ((limit == 0) ? 1 : limit)
            send_word(1'b0, READ_ERROR_CODE, 1'($urandom_range(0, 1)));
      end else begin
         set_register(CSR_STUCK_LIM, CSR_DATA_W'(limit));
         v = fresh_raw();
         send_word(1'b0, v, 1'b1);
         repeat ((limit == 0) ? 1 : limit)
            send_word(1'b0, v, 1'($urandom_range(0, 1)));
      end
      repeat (20) send_random_word(1'b0);

      hold_requests();
      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("** load_cell_sample_filter: PASSED **");
      else
         $display("** load_cell_sample_filter: FAILED **");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/lcsf_pkg.sv
rtl/core/lcsf_ring.sv
rtl/core/lcsf_divider.sv
rtl/core/load_cell_sample_filter.sv
sim/load_cell_sample_filter_tb.sv
